// ===== rtl/piecewise_linear_interpolator_unit_defines.svh =====
// assertion macros used by the interpolator checker (plim_chk)
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_UNIT_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PLIM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PLIM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/plim_pkg.sv =====
// shared types, constants and state encodings of the interpolator
package plim_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int DIV_CNT_W   = $clog2(PROD_W);
    localparam int PADDR_W     = 3;

    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [DATA_W-1:0]    t_data;
    typedef logic [PROD_W-1:0]    t_prod;
    typedef logic [DIV_CNT_W-1:0] t_div_cnt;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_POINT_COUNT  = 1'b0;
    localparam logic REG_ZERO_OUTSIDE = 1'b1;

    localparam t_data SAT_MAX = 32'h7fff_ffff;
    localparam t_data SAT_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_CHK,
        S_PROBE,
        S_CMP,
        S_FETCH_LO,
        S_DIFF,
        S_MUL,
        S_WAIT,
        S_OUT
    } t_plim_state;

    typedef enum logic {
        D_IDLE,
        D_RUN
    } t_div_state;

endpackage

// ===== rtl/plim_if.sv =====
// valid/ready channel interfaces for queries and results

interface plim_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [5:0]  point_index;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] query;
    logic        last_query;

    modport source (
        output valid, op, point_index, point_x, point_y, query, last_query,
        input  ready
    );
    modport sink (
        input  valid, op, point_index, point_x, point_y, query, last_query,
        output ready
    );
endinterface

interface plim_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_value;
    logic        out_last;

    modport source (
        output valid, out_value, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_value, out_last,
        output ready
    );
endinterface

// ===== rtl/plim_div.sv =====
// 32x32 multiply followed by a restoring divide, one quotient bit per cycle
module plim_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  plim_pkg::t_data         i_a,
    input  plim_pkg::t_data         i_b,
    input  plim_pkg::t_data         i_d,
    output logic                    o_done,
    output plim_pkg::t_prod         o_quot
);

    plim_pkg::t_div_state r_state, n_state;
    plim_pkg::t_div_cnt   r_cnt, n_cnt;
    logic                 r_done, n_done;
    plim_pkg::t_prod      r_dvd, n_dvd;
    plim_pkg::t_data      r_rem, n_rem;
    plim_pkg::t_data      r_d, n_d;

    logic [plim_pkg::DATA_W:0] step_t;
    logic [plim_pkg::DATA_W:0] step_r;
    logic                      step_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plim_pkg::D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        step_t  = {r_rem, r_dvd[plim_pkg::PROD_W-1]};
        step_ge = (step_t >= {1'b0, r_d});
        step_r  = step_ge ? (step_t - {1'b0, r_d}) : step_t;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_d     = r_d;
        unique case (r_state)
            plim_pkg::D_IDLE: begin
                if (i_start) begin
                    n_dvd   = plim_pkg::t_prod'(i_a) * plim_pkg::t_prod'(i_b);
                    n_rem   = '0;
                    n_d     = i_d;
                    n_cnt   = '0;
                    n_state = plim_pkg::D_RUN;
                end
            end
            plim_pkg::D_RUN: begin
                n_rem = step_r[plim_pkg::DATA_W-1:0];
                n_dvd = {r_dvd[plim_pkg::PROD_W-2:0], step_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_done  = 1'b1;
                    n_state = plim_pkg::D_IDLE;
                end
            end
            default: n_state = plim_pkg::D_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

// ===== rtl/piecewise_linear_interpolator_unit.sv =====
// piecewise linear interpolator: breakpoint table, binary search and interpolation
//
// usage
// - i_in carries one transaction per item: op selects a breakpoint write (point_index,
//   point_x, point_y) or a query (query, last_query); o_out returns one result per
//   query (out_value, out_last) and nothing for a write
// - breakpoints x must ascend across entries; the apb port sets point_count (0x0) and
//   zero_outside (0x4) and may only be written while no query is in flight
// - a write lands in the table as it is accepted; a query reads the first and last
//   entries, runs a binary search of at most ceil(log2(n+1)) probes through the
//   single read port of the table memory, then reads the bracketing pair
// - a query that interpolates adds the 32x32 multiply and the 64-step restoring
//   divide; one that ends at an end value or exact match skips both
// - one item is worked at a time; i_in.ready is high only while the sequencer waits,
//   so the next query can be taken in the cycle after the previous result is handed over
// - a finished result sits in the output register, so the next transaction is taken
//   while the receiver stalls; a second result waits in the sequencer until taken
// - reset sets point_count to 1 and zero_outside to 0 and empties the output;
//   table entries are undefined until written and are not cleared
module piecewise_linear_interpolator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    plim_in_if.sink                       i_in,
    plim_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [plim_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // difference a - b: sign and magnitude (magnitude always fits 32 bits)
    function automatic logic [32:0] f_abs_diff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        logic [32:0] m;
        d = {a[31], a} - {b[31], b};
        m = d[32] ? (33'd0 - d) : d;
        return {d[32], m[31:0]};
    endfunction

    // y0 plus or minus the quotient, saturated to 32 bits signed
    function automatic plim_pkg::t_data f_finish(input plim_pkg::t_data y0, input logic neg,
                                                 input plim_pkg::t_prod quot);
        logic [34:0] ys;
        logic [34:0] mag;
        logic [34:0] s;
        ys  = {{3{y0[31]}}, y0};
        mag = {2'b00, quot[32:0]};
        s   = neg ? (ys - mag) : (ys + mag);
        if (|quot[63:33]) begin
            return neg ? plim_pkg::SAT_MIN : plim_pkg::SAT_MAX;
        end
        if (!s[34] && (|s[33:31])) begin
            return plim_pkg::SAT_MAX;
        end
        if (s[34] && !(&s[33:31])) begin
            return plim_pkg::SAT_MIN;
        end
        return s[31:0];
    endfunction

    // configuration registers
    logic [6:0] r_point_count;
    logic       r_zero_outside;

    // sequencer state
    plim_pkg::t_plim_state r_state, n_state;
    logic                  r_out_valid, n_out_valid;

    // query working registers
    plim_pkg::t_data r_q, n_q;
    logic            r_last, n_last;
    plim_pkg::t_cnt  r_lo, n_lo;
    plim_pkg::t_cnt  r_len, n_len;
    plim_pkg::t_data r_x_first, n_x_first;
    plim_pkg::t_data r_y_first, n_y_first;
    plim_pkg::t_data r_y_last, n_y_last;
    plim_pkg::t_data r_x1, n_x1;
    plim_pkg::t_data r_y1, n_y1;
    plim_pkg::t_data r_y0, n_y0;
    plim_pkg::t_data r_a, n_a;
    plim_pkg::t_data r_b, n_b;
    plim_pkg::t_data r_d, n_d;
    logic            r_neg, n_neg;
    plim_pkg::t_data r_res, n_res;
    plim_pkg::t_data r_out_value, n_out_value;
    logic            r_out_last, n_out_last;

    // breakpoint memory, {x, y} per entry, one write and one registered read port
    logic [plim_pkg::PROD_W-1:0] r_mem [plim_pkg::TABLE_DEPTH];
    logic [plim_pkg::PROD_W-1:0] r_rd_data;
    plim_pkg::t_addr             rd_addr;
    logic                        mem_we;
    plim_pkg::t_data             rd_x;
    plim_pkg::t_data             rd_y;

    logic            in_ready;
    logic            in_acc;
    logic            cfg_we;
    plim_pkg::t_cnt  cnt;
    plim_pkg::t_cnt  half;
    plim_pkg::t_data end_val_first;
    plim_pkg::t_data end_val_last;
    logic [32:0]     dy;
    logic [32:0]     dq;
    logic [32:0]     dx;
    logic            div_start;
    logic            div_done;
    plim_pkg::t_prod div_quot;

    assign rd_x = r_rd_data[plim_pkg::PROD_W-1:plim_pkg::DATA_W];
    assign rd_y = r_rd_data[plim_pkg::DATA_W-1:0];

    // apb register file, zero wait states
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count  <= 7'd1;
            r_zero_outside <= 1'b0;
        end else if (cfg_we) begin
            unique case (paddr[2])
                plim_pkg::REG_POINT_COUNT:  r_point_count  <= pwdata[6:0];
                plim_pkg::REG_ZERO_OUTSIDE: r_zero_outside <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            plim_pkg::REG_POINT_COUNT:  prdata = {25'd0, r_point_count};
            plim_pkg::REG_ZERO_OUTSIDE: prdata = {31'd0, r_zero_outside};
            default:                    prdata = '0;
        endcase
    end

    // effective count: zero acts as one, clipped to the table depth
    always_comb begin
        if (r_point_count == 7'd0) begin
            cnt = plim_pkg::t_cnt'(1);
        end else if (32'(r_point_count) > 32'(plim_pkg::TABLE_DEPTH)) begin
            cnt = plim_pkg::t_cnt'(plim_pkg::TABLE_DEPTH);
        end else begin
            cnt = plim_pkg::t_cnt'(r_point_count);
        end
    end

    // input side: one transaction at a time, writes land in the memory at once
    assign in_ready    = (r_state == plim_pkg::S_IDLE);
    assign in_acc      = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign mem_we      = in_acc && (i_in.op == plim_pkg::OP_WRITE)
                         && (32'(i_in.point_index) < 32'(plim_pkg::TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[plim_pkg::t_addr'(i_in.point_index)] <= {i_in.point_x, i_in.point_y};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // multiply and divide unit
    plim_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (r_a),
        .i_b     (r_b),
        .i_d     (r_d),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plim_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q         <= n_q;
        r_last      <= n_last;
        r_lo        <= n_lo;
        r_len       <= n_len;
        r_x_first   <= n_x_first;
        r_y_first   <= n_y_first;
        r_y_last    <= n_y_last;
        r_x1        <= n_x1;
        r_y1        <= n_y1;
        r_y0        <= n_y0;
        r_a         <= n_a;
        r_b         <= n_b;
        r_d         <= n_d;
        r_neg       <= n_neg;
        r_res       <= n_res;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    // end-value rule for either side of the table
    assign end_val_first = r_zero_outside ? '0 : r_y_first;
    assign end_val_last  = r_zero_outside ? '0 : r_y_last;
    assign half          = r_len >> 1;

    // differences for interpolation: y1 - y0, q - x0, x1 - x0
    assign dy = f_abs_diff(r_y1, rd_y);
    assign dq = f_abs_diff(r_q, rd_x);
    assign dx = f_abs_diff(r_x1, rd_x);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_q         = r_q;
        n_last      = r_last;
        n_lo        = r_lo;
        n_len       = r_len;
        n_x_first   = r_x_first;
        n_y_first   = r_y_first;
        n_y_last    = r_y_last;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_y0        = r_y0;
        n_a         = r_a;
        n_b         = r_b;
        n_d         = r_d;
        n_neg       = r_neg;
        n_res       = r_res;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        rd_addr     = '0;
        div_start   = 1'b0;

        // receiver took the held result
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            plim_pkg::S_IDLE: begin
                // entry 0 is read while the query is latched
                if (in_acc && (i_in.op == plim_pkg::OP_QUERY)) begin
                    n_q     = i_in.query;
                    n_last  = i_in.last_query;
                    n_state = plim_pkg::S_LAST;
                end
            end
            plim_pkg::S_LAST: begin
                n_x_first = rd_x;
                n_y_first = rd_y;
                rd_addr   = plim_pkg::t_addr'(cnt - 1'b1);
                n_state   = plim_pkg::S_CHK;
            end
            plim_pkg::S_CHK: begin
                n_y_last = rd_y;
                if ($signed(r_q) < $signed(r_x_first)) begin
                    n_res   = end_val_first;
                    n_state = plim_pkg::S_OUT;
                end else if ($signed(r_q) > $signed(rd_x)) begin
                    n_res   = r_zero_outside ? '0 : rd_y;
                    n_state = plim_pkg::S_OUT;
                end else begin
                    n_lo    = '0;
                    n_len   = cnt;
                    n_state = plim_pkg::S_PROBE;
                end
            end
            plim_pkg::S_PROBE: begin
                if (r_len == '0) begin
                    // search done: lo is the first entry at or above the query
                    if (r_lo == cnt) begin
                        n_res   = (r_lo == '0) ? end_val_first : end_val_last;
                        n_state = plim_pkg::S_OUT;
                    end else begin
                        rd_addr = plim_pkg::t_addr'(r_lo);
                        n_state = plim_pkg::S_FETCH_LO;
                    end
                end else begin
                    rd_addr = plim_pkg::t_addr'(r_lo + half);
                    n_state = plim_pkg::S_CMP;
                end
            end
            plim_pkg::S_CMP: begin
                if ($signed(rd_x) < $signed(r_q)) begin
                    n_lo  = r_lo + half + 1'b1;
                    n_len = r_len - half - 1'b1;
                end else begin
                    n_len = half;
                end
                n_state = plim_pkg::S_PROBE;
            end
            plim_pkg::S_FETCH_LO: begin
                n_x1 = rd_x;
                n_y1 = rd_y;
                if (rd_x == r_q) begin
                    n_res   = rd_y;
                    n_state = plim_pkg::S_OUT;
                end else if (r_lo == '0) begin
                    n_res   = end_val_first;
                    n_state = plim_pkg::S_OUT;
                end else begin
                    rd_addr = plim_pkg::t_addr'(r_lo - 1'b1);
                    n_state = plim_pkg::S_DIFF;
                end
            end
            plim_pkg::S_DIFF: begin
                // rd holds the lower neighbor (x0, y0)
                n_y0 = rd_y;
                if (rd_x == r_x1) begin
                    n_res   = rd_y;
                    n_state = plim_pkg::S_OUT;
                end else begin
                    n_a     = dy[31:0];
                    n_b     = dq[31:0];
                    n_d     = dx[31:0];
                    n_neg   = dy[32] ^ dq[32] ^ dx[32];
                    n_state = plim_pkg::S_MUL;
                end
            end
            plim_pkg::S_MUL: begin
                div_start = 1'b1;
                n_state   = plim_pkg::S_WAIT;
            end
            plim_pkg::S_WAIT: begin
                if (div_done) begin
                    n_res   = f_finish(r_y0, r_neg, div_quot);
                    n_state = plim_pkg::S_OUT;
                end
            end
            plim_pkg::S_OUT: begin
                // hand over once the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res;
                    n_out_last  = r_last;
                    n_state     = plim_pkg::S_IDLE;
                end
            end
            default: n_state = plim_pkg::S_IDLE;
        endcase
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_value = r_out_value;
    assign o_out.out_last  = r_out_last;

endmodule

// ===== rtl/plim_chk.sv =====
// port-level checks of the interpolator, bound to the top level
`include "piecewise_linear_interpolator_unit_defines.svh"

module plim_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_op,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value
);

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // a breakpoint write never produces a result
    `PLIM_ASSERT_NEXT(a_write_no_result, i_clk, i_rst_n, in_acc && (i_in_op == plim_pkg::OP_WRITE) && !i_out_valid, !i_out_valid, "result appeared after a breakpoint write")

    // a query holds off further transactions while it is worked
    `PLIM_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, in_acc && (i_in_op == plim_pkg::OP_QUERY), !i_in_ready, "input ready right after a query")

    // a new result only comes out of a busy cycle
    `PLIM_ASSERT_IMPL(a_result_from_work, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_in_ready), "result appeared while idle")

    // a stalled result stays and holds its value
    `PLIM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_value), "stalled result dropped or changed")

endmodule

bind piecewise_linear_interpolator_unit plim_chk u_plim_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.out_value)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the piecewise linear interpolator unit
module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam int IDLE_PERCENT   = 21;
    localparam int PHASE_QUERIES  = 125;
    localparam int PHASE_COUNT    = 10;

    // one input transaction: a breakpoint write or a query
    typedef struct {
        logic        op;
        logic [5:0]  point_index;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] query;
        logic        last_query;
    } t_lookup_item;

    typedef struct {
        logic [31:0] value;
        logic        last;
    } t_lookup_result;

    // how the breakpoint abscissas of a phase are laid out
    typedef enum {ASC_WIDE, ASC_DENSE, JUMBLED_NARROW, JUMBLED_WIDE} t_table_shape;

    // mirror of the breakpoint table and registers, plus the queue of pending answers
    class lookup_scoreboard;
        logic signed [31:0] bp_x [plim_pkg::TABLE_DEPTH];
        logic signed [31:0] bp_y [plim_pkg::TABLE_DEPTH];
        logic [6:0]         point_count;
        logic               zero_outside;
        t_lookup_result     pending_results [$];
        int                 mismatches;

        function new();
            foreach (bp_x[i]) begin
                bp_x[i] = '0;
                bp_y[i] = '0;
            end
            point_count  = 7'd1;
            zero_outside = 1'b0;
            mismatches   = 0;
        endfunction

        // count 0 behaves as 1, anything past the table depth as the depth
        function int active_points();
            if (point_count == 0) return 1;
            if (32'(point_count) > plim_pkg::TABLE_DEPTH) return plim_pkg::TABLE_DEPTH;
            return 32'(point_count);
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == plim_pkg::REG_POINT_COUNT) begin
                point_count = value[6:0];
            end else begin
                zero_outside = value[0];
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function logic [31:0] saturate(longint v);
            if (v > 64'sd2147483647) return plim_pkg::SAT_MAX;
            if (v < -64'sd2147483648) return plim_pkg::SAT_MIN;
            return v[31:0];
        endfunction

        // y0 + (dy * dq) / dx with an exact product and a quotient truncated toward zero
        function logic [31:0] blend(longint y0, longint dy, longint dq, longint dx);
            bit         neg;
            bit [127:0] a;
            bit [127:0] b;
            bit [127:0] d;
            bit [127:0] quo;
            neg = ((dy < 0) != (dq < 0)) != (dx < 0);
            a = 128'((dy < 0) ? -dy : dy);
            b = 128'((dq < 0) ? -dq : dq);
            d = 128'((dx < 0) ? -dx : dx);
            if (a == 0 || b == 0) return saturate(y0);
            quo = (a * b) / d;
            if (quo > (128'd1 << 40)) return neg ? plim_pkg::SAT_MIN : plim_pkg::SAT_MAX;
            return saturate(neg ? y0 - longint'(quo[63:0]) : y0 + longint'(quo[63:0]));
        endfunction

        function logic [31:0] lookup_value(logic signed [31:0] q);
            int n;
            int lo;
            int len;
            int half;
            n = active_points();
            if (q < bp_x[0]) return zero_outside ? 32'h0 : bp_y[0];
            if (q > bp_x[n-1]) return zero_outside ? 32'h0 : bp_y[n-1];
            // lower-bound search: first entry whose abscissa is not below the query
            lo  = 0;
            len = n;
            while (len > 0) begin
                half = len / 2;
                if (bp_x[lo + half] < q) begin
                    lo  += half + 1;
                    len -= half + 1;
                end else begin
                    len = half;
                end
            end
            if (lo < n && bp_x[lo] == q) return bp_y[lo];
            if (lo > 0 && lo < n) begin
                if (bp_x[lo] == bp_x[lo-1]) return bp_y[lo-1];
                return blend(longint'(bp_y[lo-1]),
                             longint'(bp_y[lo]) - longint'(bp_y[lo-1]),
                             longint'(q) - longint'(bp_x[lo-1]),
                             longint'(bp_x[lo]) - longint'(bp_x[lo-1]));
            end
            if (zero_outside) return 32'h0;
            return (lo == 0) ? bp_y[0] : bp_y[n-1];
        endfunction

        function void note_item(t_lookup_item it);
            t_lookup_result want;
            if (it.op == plim_pkg::OP_WRITE) begin
                bp_x[it.point_index] = it.point_x;
                bp_y[it.point_index] = it.point_y;
            end else begin
                want.value = lookup_value(signed'(it.query));
                want.last  = it.last_query;
                pending_results.push_back(want);
            end
        endfunction

        function void check_result(logic [31:0] value, logic last);
            t_lookup_result want;
            if (pending_results.size() == 0) begin
                $error("out_value: no query waiting, got %h", value);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (value !== want.value) begin
                $error("out_value: expected %h, got %h", want.value, value);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("out_last: expected %b, got %b", want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [plim_pkg::PADDR_W-1:0]   paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    plim_in_if  in_ch ();
    plim_out_if out_ch ();

    lookup_scoreboard sb;
    bit steady       = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;
    int quiet_cycles = 0;

    piecewise_linear_interpolator_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog: ends the run when no transaction moves on either side for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin : result_sink
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                sb.check_result(out_ch.out_value, out_ch.out_last);
            end
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    function automatic t_lookup_item breakpoint(int idx, logic [31:0] x, logic [31:0] y);
        t_lookup_item it;
        it.op          = plim_pkg::OP_WRITE;
        it.point_index = idx[5:0];
        it.point_x     = x;
        it.point_y     = y;
        it.query       = $urandom;
        it.last_query  = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic t_lookup_item probe(logic [31:0] q, logic last);
        t_lookup_item it;
        it.op          = plim_pkg::OP_QUERY;
        it.point_index = 6'($urandom_range(plim_pkg::TABLE_DEPTH - 1));
        it.point_x     = $urandom;
        it.point_y     = $urandom;
        it.query       = q;
        it.last_query  = last;
        return it;
    endfunction

    // new ordinate for any entry; ascending layouts keep the abscissa of active entries
    function automatic t_lookup_item rewrite(t_table_shape shape, int m);
        int          idx;
        logic [31:0] x;
        idx = $urandom_range(plim_pkg::TABLE_DEPTH - 1);
        if ((shape == ASC_WIDE || shape == ASC_DENSE) && idx < m) begin
            x = sb.bp_x[idx];
        end else begin
            x = $urandom;
        end
        return breakpoint(idx, x, $urandom);
    endfunction

    // queries: wild values, exact breakpoints, off-by-one, and points inside the range
    function automatic logic [31:0] pick_query(int m);
        logic signed [31:0] a;
        logic signed [31:0] b;
        longint             lo;
        longint             span;
        bit [63:0]          off;
        int                 r;
        a = sb.bp_x[0];
        b = sb.bp_x[m-1];
        r = $urandom_range(99);
        if (r < 15) return $urandom;
        if (r < 35) return sb.bp_x[$urandom_range(m - 1)];
        if (r < 45) return sb.bp_x[$urandom_range(m - 1)] + ($urandom_range(1) ? 1 : -1);
        lo   = (a < b) ? a : b;
        span = ((a < b) ? longint'(b) : longint'(a)) - lo + 1;
        off  = {$urandom, $urandom} % 64'(span);
        return 32'(lo + longint'(off));
    endfunction

    task automatic send_item(t_lookup_item it);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= it.op;
        in_ch.point_index <= it.point_index;
        in_ch.point_x     <= it.point_x;
        in_ch.point_y     <= it.point_y;
        in_ch.query       <= it.query;
        in_ch.last_query  <= it.last_query;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_item(it);
    endtask

    // stop offering, wait for every answer, then let a trailing write finish
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= plim_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // stay idle so the next setup phase starts on a fresh edge
        @(posedge i_clk);
        sb.set_register(idx, value);
    endtask

    task automatic configure(logic [31:0] count, logic fill);
        write_register(plim_pkg::REG_POINT_COUNT, count);
        write_register(plim_pkg::REG_ZERO_OUTSIDE, {31'd0, fill});
    endtask

    task automatic directed_checks();
        configure(32'd4, 1'b0);
        // four points with extreme ordinates and slopes of both signs
        send_item(breakpoint(0, -32'sh20000, 32'h7fffffff));
        send_item(breakpoint(1, 32'h0, 32'h80000000));
        send_item(breakpoint(2, 32'h10000, 32'h00050000));
        send_item(breakpoint(3, 32'h30000, 32'hfffe0000));
        // outside the range holds the end values
        send_item(probe(32'h80000000, 1'b0));
        send_item(probe(32'h7fffffff, 1'b1));
        // exact matches at the first, last and a middle entry
        send_item(probe(-32'sh20000, 1'b0));
        send_item(probe(32'h30000, 1'b0));
        send_item(probe(32'h0, 1'b0));
        send_item(probe(32'h10000, 1'b1));
        // interpolation, including the full-scale drop and points next to breakpoints
        send_item(probe(-32'sh10000, 1'b0));
        send_item(probe(32'h8000, 1'b0));
        send_item(probe(32'h18000, 1'b0));
        send_item(probe(32'h2ffff, 1'b0));
        send_item(probe(-32'sh1ffff, 1'b1));
        quiesce();
        // zero outside the range
        configure(32'd4, 1'b1);
        send_item(probe(32'h80000000, 1'b0));
        send_item(probe(32'h7fffffff, 1'b0));
        send_item(probe(-32'sh20001, 1'b0));
        send_item(probe(32'h30001, 1'b0));
        send_item(probe(32'h20000, 1'b1));
        // two neighbours with the same abscissa
        send_item(breakpoint(2, 32'h0, 32'h12345678));
        send_item(probe(32'h0, 1'b0));
        send_item(probe(32'h100, 1'b1));
        quiesce();
    endtask

    task automatic run_phase(int phase, logic [31:0] count, logic fill);
        t_table_shape shape;
        int           m;
        int           sent;
        longint       cur;
        logic [31:0]  x;
        shape = t_table_shape'(phase % 4);
        configure(count, fill);
        m = sb.active_points();
        if (shape == ASC_WIDE) begin
            cur = longint'($urandom_range(32'h7fffffff)) - 64'sd2147483648;
        end else begin
            cur = longint'(int'($urandom));
        end
        // every active entry is loaded before the first query reads it
        for (int i = 0; i < m; i++) begin
            case (shape)
                ASC_WIDE: begin
                    x = cur[31:0];
                    cur += $urandom_range(1, 1 << 24);
                end
                ASC_DENSE: begin
                    x = cur[31:0];
                    cur += $urandom_range(3);
                    if (cur > 64'sd2147483647) cur = 64'sd2147483647;
                end
                JUMBLED_NARROW: x = $urandom_range(16) - 8;
                default: x = $urandom;
            endcase
            send_item(breakpoint(i, x, $urandom));
        end
        if (phase == 2) hold_request = 1'b1;
        if (phase == 4) steady = 1'b1;
        sent = 0;
        while (sent < PHASE_QUERIES) begin
            if ($urandom_range(99) < 8) begin
                send_item(rewrite(shape, m));
            end else begin
                send_item(probe(pick_query(m), $urandom_range(7) == 0));
                sent++;
            end
        end
        quiesce();
        steady = 1'b0;
    endtask

    initial begin : stimulus
        int          phase_counts [PHASE_COUNT];
        bit          phase_fills [PHASE_COUNT];
        logic [31:0] count;
        logic        fill;
        sb = new();
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= plim_pkg::OP_WRITE;
        in_ch.point_index <= '0;
        in_ch.point_x     <= '0;
        in_ch.point_y     <= '0;
        in_ch.query       <= '0;
        in_ch.last_query  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_checks();

        // counts cover the smallest, the full table and the out-of-range encodings
        phase_counts = '{1, 2, 64, 0, 100, 127, 0, 64, 0, 16};
        phase_fills  = '{1, 0, 1, 0, 1, 0, 0, 0, 0, 1};
        for (int p = 0; p < PHASE_COUNT; p++) begin
            count = phase_counts[p];
            fill  = phase_fills[p];
            if (p == 6 || p == 8) begin
                count = $urandom_range(3, 63);
                fill  = 1'($urandom_range(1));
            end
            run_phase(p, count, fill);
        end

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
